FILE: rtl/core/sdesp_pkg.sv
`default_nettype none

package sdesp_pkg;

  // Byte position and packet end, in bytes (length in words times four)
  localparam int unsigned PosW     = 18;
  localparam int unsigned ChunkMin = 8;  // SSRC plus the smallest item list
  localparam int unsigned ItemHdr  = 2;  // type and length bytes
  localparam int unsigned AlignW   = 2;  // 32-bit alignment

  localparam logic [AlignW-1:0] AlignLast  = '1;
  localparam logic [AlignW-1:0] AlignFirst = '0;

  // SDES item types: null ends a chunk's item list; CNAME through NOTE are passed on
  localparam logic [7:0] TypeNull  = 8'd0;
  localparam logic [7:0] TypeCname = 8'd1;
  localparam logic [7:0] TypeNote  = 8'd7;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_SSRC = 3'd1,
    PH_TYPE = 3'd2,
    PH_LEN  = 3'd3,
    PH_DATA = 3'd4,
    PH_PAD  = 3'd5,
    PH_DONE = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_OVERRUN = 2'd2
  } kind_e;

  typedef struct packed {
    phase_e          phase;
    logic [PosW-1:0] pos;
    logic [PosW-1:0] end_pos;
    logic [4:0]      chunks_left;
    logic [31:0]     ssrc;
    logic [7:0]      cur_type;
    logic [7:0]      bytes_left;
    logic            keep;
  } state_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] source_id;
    logic [7:0]  item_type;
    logic [7:0]  item_length;
    logic [7:0]  out_byte;
    logic        last_of_item;
  } result_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [4:0]  chunk_count;
    logic [15:0] length_words;
  } request_t;

endpackage

`default_nettype wire

FILE: rtl/core/sdesp_if.sv
`default_nettype none

// Byte request channel into the parser
interface sdesp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic [4:0]  chunk_count;
  logic [15:0] length_words;

  modport source (output valid, data_byte, first_byte, chunk_count, length_words,
                  input ready);
  modport sink   (input valid, data_byte, first_byte, chunk_count, length_words,
                  output ready);
endinterface

// Item result channel out of the parser
interface sdesp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] source_id;
  logic [7:0]  item_type;
  logic [7:0]  item_length;
  logic [7:0]  out_byte;
  logic        last_of_item;

  modport source (output valid, kind, source_id, item_type, item_length, out_byte,
                  last_of_item, input ready);
  modport sink   (input valid, kind, source_id, item_type, item_length, out_byte,
                  last_of_item, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sdesp_step.sv
`default_nettype none

// One parse step: next state and optional result for one payload byte
module sdesp_step (
  input  sdesp_pkg::state_t   state_i,
  input  sdesp_pkg::request_t req_i,
  output sdesp_pkg::state_t   state_o,
  output logic                res_valid_o,
  output sdesp_pkg::result_t  res_o
);
  import sdesp_pkg::*;

  logic [PosW:0]   pos_ext;
  logic [PosW:0]   end_ext;
  logic [PosW:0]   new_end_ext;
  logic            fits_chunk;
  logic            hdr_short;
  logic            len_over;
  logic            type_kept;
  logic [7:0]      left_dec;
  logic            first_fits;
  logic            pad_boundary;
  phase_e          phase_d;

  // Shared compares
  assign pos_ext      = {1'b0, state_i.pos};
  assign end_ext      = {1'b0, state_i.end_pos};
  assign new_end_ext  = {1'b0, req_i.length_words, 2'b00};
  assign fits_chunk   = (state_i.chunks_left != '0) &&
                        (pos_ext + (PosW+1)'(ChunkMin) <= end_ext);
  assign first_fits   = (req_i.chunk_count != '0) &&
                        ((PosW+1)'(ChunkMin) <= new_end_ext);
  assign hdr_short    = (pos_ext + (PosW+1)'(ItemHdr) > end_ext);
  assign len_over     = (pos_ext + (PosW+1)'(1) + (PosW+1)'(req_i.data_byte) > end_ext);
  assign type_kept    = req_i.data_byte inside {[TypeCname:TypeNote]};
  assign left_dec     = state_i.bytes_left - 8'd1;
  assign pad_boundary = (state_i.pos[AlignW-1:0] == AlignFirst);

  // Next phase
  always_comb begin
    phase_d = state_i.phase;
    if (req_i.first_byte) begin
      phase_d = first_fits ? PH_SSRC : PH_DONE;
    end else begin
      case (state_i.phase)
        PH_SSRC: begin
          if (state_i.pos[AlignW-1:0] == AlignLast) phase_d = PH_TYPE;
        end
        PH_TYPE: begin
          if (hdr_short)                         phase_d = PH_DONE;
          else if (req_i.data_byte == TypeNull)  phase_d = PH_PAD;
          else                                   phase_d = PH_LEN;
        end
        PH_LEN: begin
          if (len_over)                    phase_d = PH_DONE;
          else if (req_i.data_byte != '0)  phase_d = PH_DATA;
          else                             phase_d = PH_TYPE;
        end
        PH_DATA: begin
          if (left_dec == '0) phase_d = PH_TYPE;
        end
        PH_PAD: begin
          if (pad_boundary) phase_d = fits_chunk ? PH_SSRC : PH_DONE;
        end
        default: phase_d = state_i.phase;
      endcase
    end
  end

  // Datapath and result
  always_comb begin
    state_o              = state_i;
    state_o.phase        = phase_d;
    res_valid_o          = 1'b0;
    res_o.kind           = KIND_START;
    res_o.source_id      = state_i.ssrc;
    res_o.item_type      = state_i.cur_type;
    res_o.item_length    = '0;
    res_o.out_byte       = '0;
    res_o.last_of_item   = 1'b0;

    if (req_i.first_byte) begin
      state_o.end_pos     = {req_i.length_words, 2'b00};
      state_o.chunks_left = req_i.chunk_count;
      state_o.ssrc        = first_fits ? {24'd0, req_i.data_byte} : '0;
      state_o.cur_type    = '0;
      state_o.bytes_left  = '0;
      state_o.keep        = 1'b0;
      state_o.pos         = first_fits ? PosW'(1) : '0;
    end else begin
      case (state_i.phase)
        PH_SSRC: state_o.ssrc = {state_i.ssrc[23:0], req_i.data_byte};
        PH_TYPE: begin
          if (!hdr_short) begin
            if (req_i.data_byte == TypeNull) begin
              state_o.chunks_left = state_i.chunks_left - 5'd1;
            end else begin
              state_o.cur_type = req_i.data_byte;
              state_o.keep     = type_kept;
            end
          end
        end
        PH_LEN: begin
          res_o.item_length = req_i.data_byte;
          if (len_over) begin
            res_valid_o        = 1'b1;
            res_o.kind         = KIND_OVERRUN;
            res_o.last_of_item = 1'b1;
          end else begin
            res_valid_o        = state_i.keep;
            res_o.kind         = KIND_START;
            res_o.last_of_item = (req_i.data_byte == '0);
            state_o.bytes_left = req_i.data_byte;
          end
        end
        PH_DATA: begin
          state_o.bytes_left = left_dec;
          res_valid_o        = state_i.keep;
          res_o.kind         = KIND_DATA;
          res_o.out_byte     = req_i.data_byte;
          res_o.last_of_item = (left_dec == '0);
        end
        PH_PAD: begin
          if (pad_boundary && fits_chunk) state_o.ssrc = {24'd0, req_i.data_byte};
        end
        default: state_o.ssrc = state_i.ssrc;
      endcase

      // Position advances in active phases unless the packet just finished
      if ((state_i.phase != PH_IDLE) && (state_i.phase != PH_DONE) &&
          (phase_d != PH_DONE)) begin
        state_o.pos = state_i.pos + PosW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rtcp_sdes_chunk_parser.sv
`default_nettype none

// Channel  | Dir | Payload                                                  | Handshake
// in_i     | in  | data_byte, first_byte, chunk_count, length_words         | valid/ready
// out_o    | out | kind, source_id, item_type, item_length, out_byte, last  | valid/ready
//
// One byte per clock while in_i.ready is high: the parse state updates at each accepted request and at
// most one result enters the output register in the same cycle.
// A result appears on out_o in the cycle after its byte is accepted.
// in_i.ready drops only while the output register holds a result that is not taken.
// rst_ni (asynchronous, active low) returns the parser to idle with an empty output.
module rtcp_sdes_chunk_parser (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  sdesp_in_if.sink     in_i,
  sdesp_out_if.source  out_o
);
  import sdesp_pkg::*;

  state_t   state_q, state_d;
  result_t  res_q, step_res;
  logic     step_valid;
  logic     out_valid_q, out_valid_d;
  logic     accept;
  request_t req;

  assign req.data_byte    = in_i.data_byte;
  assign req.first_byte   = in_i.first_byte;
  assign req.chunk_count  = in_i.chunk_count;
  assign req.length_words = in_i.length_words;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  sdesp_step u_step (
    .state_i     (state_q),
    .req_i       (req),
    .state_o     (state_d),
    .res_valid_o (step_valid),
    .res_o       (step_res)
  );

  // Output register occupancy
  always_comb begin
    if (accept) out_valid_d = step_valid;
    else        out_valid_d = out_valid_q && !out_o.ready;
  end

  // Parse state and output control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept && step_valid) res_q <= step_res;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = res_q.kind;
  assign out_o.source_id    = res_q.source_id;
  assign out_o.item_type    = res_q.item_type;
  assign out_o.item_length  = res_q.item_length;
  assign out_o.out_byte     = res_q.out_byte;
  assign out_o.last_of_item = res_q.last_of_item;

endmodule

`default_nettype wire

FILE: rtl/core/sdesp_checker.sv
`default_nettype none

module sdesp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [1:0]  out_kind_i,
  input wire logic [31:0] out_source_id_i,
  input wire logic [7:0]  out_item_length_i,
  input wire logic [7:0]  out_byte_i,
  input wire logic        out_last_i
);
  import sdesp_pkg::*;

  // A stalled result stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its source ID and output byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_source_id_i) && $stable(out_byte_i))
    else $error("result changed while stalled");

  // Empty output never blocks the byte stream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // Overrun ends the item and carries no byte; data results carry no length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KIND_OVERRUN) |-> out_last_i && (out_byte_i == '0))
    else $error("overrun result malformed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((out_kind_i == KIND_DATA) && (out_item_length_i == '0)) ||
                    ((out_kind_i == KIND_START) && (out_byte_i == '0)) ||
                    (out_kind_i == KIND_OVERRUN))
    else $error("result kind or fields invalid");

endmodule

bind rtcp_sdes_chunk_parser sdesp_checker u_sdesp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_kind_i        (out_o.kind),
  .out_source_id_i   (out_o.source_id),
  .out_item_length_i (out_o.item_length),
  .out_byte_i        (out_o.out_byte),
  .out_last_i        (out_o.last_of_item)
);

`default_nettype wire
